FILE: sv/sha1_pkg.sv
// shared types, constants and helper functions of the sha-1 hash engine
`default_nettype none

package sha1_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned LEN_W      = 64;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned WIB_W      = 4;
  localparam int unsigned ROUND_W    = 7;
  localparam int unsigned WIN_DEPTH  = 16;
  localparam int unsigned NUM_DIGEST = 5;

  localparam logic [7:0]         PAD_BYTE    = 8'h80;
  localparam logic [CNT_W-1:0]   FULL_COUNT  = 3'd4;
  localparam logic [CNT_W-1:0]   LAST_INDEX  = 3'd4;
  localparam logic [WIB_W-1:0]   WIB_LAST    = 4'd15;
  localparam logic [WIB_W-1:0]   LEN_POS     = 4'd14;
  localparam logic [ROUND_W-1:0] LAST_ROUND  = 7'd79;
  localparam logic [ROUND_W-1:0] PAR0_START  = 7'd20;
  localparam logic [ROUND_W-1:0] MAJ_START   = 7'd40;
  localparam logic [ROUND_W-1:0] PAR1_START  = 7'd60;
  localparam logic [LEN_W-1:0]   FULL_BITS   = 64'd32;

  localparam logic [WORD_W-1:0] INIT_CHAIN [NUM_DIGEST] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ZERO,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_ROUND,
    ST_ADD,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    WSEL_DATA,
    WSEL_LAST,
    WSEL_PAD,
    WSEL_ZERO,
    WSEL_LEN_HI,
    WSEL_LEN_LO
  } word_sel_t;

  typedef enum logic [1:0] {
    RF_CH,
    RF_PAR0,
    RF_MAJ,
    RF_PAR1
  } round_fn_t;

  typedef struct packed {
    logic      push;
    word_sel_t word_sel;
    logic      load_work;
    logic      round;
    round_fn_t round_fn;
    logic      add_chain;
    logic      finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] count_clamp(input logic [CNT_W-1:0] bc);
    count_clamp = (bc > FULL_COUNT) ? FULL_COUNT : bc;
  endfunction

  function automatic logic [WORD_W-1:0] last_word(input logic [WORD_W-1:0] data,
                                                  input logic [CNT_W-1:0]  cnt);
    case (cnt)
      3'd0:    last_word = {PAD_BYTE, 24'h000000};
      3'd1:    last_word = {data[31:24], PAD_BYTE, 16'h0000};
      3'd2:    last_word = {data[31:16], PAD_BYTE, 8'h00};
      3'd3:    last_word = {data[31:8], PAD_BYTE};
      default: last_word = data;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rf_value(input round_fn_t fn,
                                                 input logic [WORD_W-1:0] b,
                                                 input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] d);
    case (fn)
      RF_CH:   rf_value = (b & c) | (~b & d);
      RF_MAJ:  rf_value = (b & c) | (b & d) | (c & d);
      default: rf_value = b ^ c ^ d;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rf_const(input round_fn_t fn);
    case (fn)
      RF_CH:   rf_const = 32'h5A827999;
      RF_PAR0: rf_const = 32'h6ED9EBA1;
      RF_MAJ:  rf_const = 32'h8F1BBCDC;
      default: rf_const = 32'hCA62C1D6;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: sv/sha1_ctrl.sv
// sha-1 controller: word intake, padding sequence and round sequencing
`default_nettype none

module sha1_ctrl
  import sha1_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [CNT_W-1:0] in_byte_count,
  input  wire logic             in_end_of_message,
  output logic                  in_stall,
  output dp_cmd_t               cmd,
  input  wire dp_stat_t         stat
);

  ctrl_state_t          state_r, state_nxt;
  ctrl_state_t          resume_r, resume_nxt;
  logic [WIB_W-1:0]     wib_r, wib_nxt;
  logic [ROUND_W-1:0]   rnd_r, rnd_nxt;
  logic                 wrap;
  ctrl_state_t          pad_flow;

  assign wrap     = (wib_r == WIB_LAST);
  assign pad_flow = (4'(wib_r + 4'd1) == LEN_POS) ? ST_LEN_HI : ST_ZERO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      resume_r <= ST_IDLE;
      wib_r    <= '0;
      rnd_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      resume_r <= resume_nxt;
      wib_r    <= wib_nxt;
      rnd_r    <= rnd_nxt;
    end
  end

  // next state
  always_comb begin
    ctrl_state_t flow;
    flow       = ST_ZERO;
    state_nxt  = state_r;
    resume_nxt = resume_r;
    wib_nxt    = wib_r;
    rnd_nxt    = rnd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          wib_nxt = 4'(wib_r + 4'd1);
          if (!in_end_of_message) begin
            flow = ST_IDLE;
          end else if (count_clamp(in_byte_count) == FULL_COUNT) begin
            flow = ST_PAD;
          end else begin
            flow = pad_flow;
          end
          if (wrap) begin
            state_nxt  = ST_ROUND;
            resume_nxt = flow;
          end else begin
            state_nxt = flow;
          end
        end
      end
      ST_PAD, ST_ZERO: begin
        wib_nxt = 4'(wib_r + 4'd1);
        if (wrap) begin
          state_nxt  = ST_ROUND;
          resume_nxt = pad_flow;
        end else begin
          state_nxt = pad_flow;
        end
      end
      ST_LEN_HI: begin
        wib_nxt   = 4'(wib_r + 4'd1);
        state_nxt = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        wib_nxt    = 4'(wib_r + 4'd1);
        state_nxt  = ST_ROUND;
        resume_nxt = ST_FINISH;
      end
      ST_ROUND: begin
        if (rnd_r == LAST_ROUND) begin
          rnd_nxt   = '0;
          state_nxt = ST_ADD;
        end else begin
          rnd_nxt = 7'(rnd_r + 7'd1);
        end
      end
      ST_ADD: begin
        state_nxt = resume_r;
      end
      ST_FINISH: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    if (rnd_r < PAR0_START) begin
      cmd.round_fn = RF_CH;
    end else if (rnd_r < MAJ_START) begin
      cmd.round_fn = RF_PAR0;
    end else if (rnd_r < PAR1_START) begin
      cmd.round_fn = RF_MAJ;
    end else begin
      cmd.round_fn = RF_PAR1;
    end
    case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.push      = in_valid;
        cmd.word_sel  = in_end_of_message ? WSEL_LAST : WSEL_DATA;
        cmd.load_work = in_valid && wrap;
      end
      ST_PAD: begin
        cmd.push      = 1'b1;
        cmd.word_sel  = WSEL_PAD;
        cmd.load_work = wrap;
      end
      ST_ZERO: begin
        cmd.push      = 1'b1;
        cmd.word_sel  = WSEL_ZERO;
        cmd.load_work = wrap;
      end
      ST_LEN_HI: begin
        cmd.push     = 1'b1;
        cmd.word_sel = WSEL_LEN_HI;
      end
      ST_LEN_LO: begin
        cmd.push      = 1'b1;
        cmd.word_sel  = WSEL_LEN_LO;
        cmd.load_work = 1'b1;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
      end
      ST_ADD: begin
        cmd.add_chain = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = !stat.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/sha1_dp.sv
// sha-1 datapath: schedule window, round unit, chaining values, bit count, digest output
`default_nettype none

module sha1_dp
  import sha1_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [WORD_W-1:0] in_data_word,
  input  wire logic [CNT_W-1:0]  in_byte_count,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WORD_W-1:0]      out_digest_word,
  output logic [CNT_W-1:0]       out_word_index,
  output logic                   out_last_digest_word
);

  logic [WORD_W-1:0] win_r   [WIN_DEPTH];
  logic [WORD_W-1:0] chain_r [NUM_DIGEST];
  logic [WORD_W-1:0] dig_r   [NUM_DIGEST];
  logic [WORD_W-1:0] a_r, b_r, c_r, d_r, e_r;
  logic [LEN_W-1:0]  bits_r;
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_idx_r;

  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] push_word;
  logic [WORD_W-1:0] w_mix;
  logic [WORD_W-1:0] w_new;
  logic [WORD_W-1:0] tmp;
  logic              out_take;

  assign cnt      = count_clamp(in_byte_count);
  assign w_mix    = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_new    = {w_mix[30:0], w_mix[31]};
  assign tmp      = 32'({a_r[26:0], a_r[31:27]} + rf_value(cmd.round_fn, b_r, c_r, d_r)
                        + e_r + rf_const(cmd.round_fn) + win_r[0]);
  assign out_take = out_valid_r && !out_stall;

  always_comb begin
    case (cmd.word_sel)
      WSEL_DATA:   push_word = in_data_word;
      WSEL_LAST:   push_word = last_word(in_data_word, cnt);
      WSEL_PAD:    push_word = {PAD_BYTE, 24'h000000};
      WSEL_LEN_HI: push_word = bits_r[63:32];
      WSEL_LEN_LO: push_word = bits_r[31:0];
      default:     push_word = '0;
    endcase
  end

  // schedule window: oldest word at entry zero
  always_ff @(posedge clk) begin
    if (cmd.push || cmd.round) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_DEPTH-1] <= cmd.push ? push_word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (cmd.round) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGEST; i++) begin
        chain_r[i] <= INIT_CHAIN[i];
      end
      bits_r <= '0;
    end else begin
      if (cmd.add_chain) begin
        chain_r[0] <= 32'(chain_r[0] + a_r);
        chain_r[1] <= 32'(chain_r[1] + b_r);
        chain_r[2] <= 32'(chain_r[2] + c_r);
        chain_r[3] <= 32'(chain_r[3] + d_r);
        chain_r[4] <= 32'(chain_r[4] + e_r);
      end else if (cmd.finish) begin
        for (int i = 0; i < NUM_DIGEST; i++) begin
          chain_r[i] <= INIT_CHAIN[i];
        end
      end
      if (cmd.finish) begin
        bits_r <= '0;
      end else if (cmd.push && cmd.word_sel == WSEL_DATA) begin
        bits_r <= 64'(bits_r + FULL_BITS);
      end else if (cmd.push && cmd.word_sel == WSEL_LAST) begin
        bits_r <= 64'(bits_r + {58'd0, cnt, 3'b000});
      end
    end
  end

  // digest output buffer
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int i = 0; i < NUM_DIGEST; i++) begin
        dig_r[i] <= chain_r[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < NUM_DIGEST - 1; i++) begin
        dig_r[i] <= dig_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_idx_r   <= '0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
      out_idx_r   <= '0;
    end else if (out_take) begin
      out_idx_r <= 3'(out_idx_r + 3'd1);
      if (out_idx_r == LAST_INDEX) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_busy        = out_valid_r;
  assign out_valid            = out_valid_r;
  assign out_digest_word      = dig_r[0];
  assign out_word_index       = out_idx_r;
  assign out_last_digest_word = (out_idx_r == LAST_INDEX);

endmodule

`default_nettype wire

FILE: sv/sha1_hash_engine.sv
// sha-1 hash engine top level
// A message enters as big-endian 32-bit words, one transaction per cycle while a 16-word
// block fills; the sixteenth word starts the compression, which runs 80 rounds on a single
// round unit, one round per cycle, followed by the chaining add; the input stalls during
// the rounds and the add. After the final word the engine pushes the padding and length
// words itself at one per cycle (one extra compression when they spill into a new block),
// then hands the five digest words to an output buffer and is ready for the next message
// while they drain, one transaction each, H0 first.
`default_nettype none

module sha1_hash_engine
  import sha1_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] in_data_word,
  input  wire logic [CNT_W-1:0]  in_byte_count,
  input  wire logic              in_end_of_message,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WORD_W-1:0]      out_digest_word,
  output logic [CNT_W-1:0]       out_word_index,
  output logic                   out_last_digest_word
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha1_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_byte_count     (in_byte_count),
    .in_end_of_message (in_end_of_message),
    .in_stall          (in_stall),
    .cmd               (cmd),
    .stat              (stat)
  );

  sha1_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_data_word         (in_data_word),
    .in_byte_count        (in_byte_count),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_digest_word      (out_digest_word),
    .out_word_index       (out_word_index),
    .out_last_digest_word (out_last_digest_word)
  );

endmodule

`default_nettype wire

FILE: sv/sha1_checker.sv
// port-level checks of the sha-1 hash engine and their binding
`default_nettype none

module sha1_checker
  import sha1_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [WORD_W-1:0] out_digest_word,
  input wire logic [CNT_W-1:0]  out_word_index,
  input wire logic              out_last_digest_word
);

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_digest_word == (out_word_index == LAST_INDEX)))
    else $error("last digest word flag disagrees with word index");

  a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_word_index == '0))
    else $error("digest does not start at word zero");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_digest_word) |=>
      (out_valid && out_word_index == 3'($past(out_word_index) + 3'd1)))
    else $error("digest words not delivered in order");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_digest_word) && $stable(out_word_index)))
    else $error("stalled digest transaction changed");

endmodule

bind sha1_hash_engine sha1_checker u_sha1_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_digest_word      (out_digest_word),
  .out_word_index       (out_word_index),
  .out_last_digest_word (out_last_digest_word)
);

`default_nettype wire

FILE: sim/sha1_digest_checker.sv
// checker for the sha-1 hash engine: predicts digests from accepted words and compares results
module sha1_digest_checker
  import sha1_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic [WORD_W-1:0] in_data_word,
  input  wire logic [CNT_W-1:0]  in_byte_count,
  input  wire logic              in_end_of_message,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic [WORD_W-1:0] out_digest_word,
  input  wire logic [CNT_W-1:0]  out_word_index,
  input  wire logic              out_last_digest_word,
  output int                     mismatches,
  output int                     digests_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  index;
    logic              last;
  } digest_entry_t;

  logic [WORD_W-1:0] hash_state [NUM_DIGEST];
  logic [WORD_W-1:0] msg_sched [WIN_DEPTH];
  logic [WIB_W-1:0]  words_held;
  logic [LEN_W-1:0]  bit_length;
  digest_entry_t     owed_digest_q [$];
  digest_entry_t     want;
  digest_entry_t     entry;
  logic [CNT_W-1:0]  nbytes;
  logic [WORD_W-1:0] tail_word;

  initial begin
    mismatches   = 0;
    digests_owed = 0;
  end

  function automatic logic [WORD_W-1:0] rol32(input logic [WORD_W-1:0] x, input int n);
    rol32 = (x << n) | (x >> (32 - n));
  endfunction

  task automatic compress_block();
    logic [WORD_W-1:0] a, b, c, d, e, f, k, w, t;
    int r;
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        msg_sched[r % 16] = rol32(msg_sched[(r + 13) % 16] ^ msg_sched[(r + 8) % 16]
                                  ^ msg_sched[(r + 2) % 16] ^ msg_sched[r % 16], 1);
      end
      w = msg_sched[r % 16];
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rol32(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    hash_state[0] = hash_state[0] + a;
    hash_state[1] = hash_state[1] + b;
    hash_state[2] = hash_state[2] + c;
    hash_state[3] = hash_state[3] + d;
    hash_state[4] = hash_state[4] + e;
  endtask

  task automatic push_word(input logic [WORD_W-1:0] w);
    msg_sched[words_held] = w;
    words_held = words_held + 1'b1;
    if (words_held == '0) compress_block();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_DIGEST; i++) hash_state[i] = INIT_CHAIN[i];
      for (int i = 0; i < WIN_DEPTH; i++) msg_sched[i] = '0;
      words_held = '0;
      bit_length = '0;
      owed_digest_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_digest_q.size() == 0) begin
          $error("unexpected digest word %h index %0d", out_digest_word, out_word_index);
          mismatches++;
        end else begin
          want = owed_digest_q.pop_front();
          if (out_digest_word !== want.word) begin
            $error("digest_word: expected %h, actual %h", want.word, out_digest_word);
            mismatches++;
          end
          if (out_word_index !== want.index) begin
            $error("word_index: expected %0d, actual %0d", want.index, out_word_index);
            mismatches++;
          end
          if (out_last_digest_word !== want.last) begin
            $error("last_digest_word: expected %b, actual %b", want.last,
                   out_last_digest_word);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (!in_end_of_message) begin
          // non-final words always count as four bytes
          push_word(in_data_word);
          bit_length = bit_length + 64'd32;
        end else begin
          nbytes = (in_byte_count > FULL_COUNT) ? FULL_COUNT : in_byte_count;
          bit_length = bit_length + 64'(8 * nbytes);
          tail_word = in_data_word & ~(32'hFFFF_FFFF >> (8 * nbytes));
          if (nbytes < FULL_COUNT) begin
            tail_word = tail_word | (32'(PAD_BYTE) << (24 - 8 * nbytes));
            push_word(tail_word);
          end else begin
            push_word(tail_word);
            push_word({PAD_BYTE, 24'h000000});
          end
          while (words_held != LEN_POS) push_word('0);
          push_word(bit_length[63:32]);
          push_word(bit_length[31:0]);
          for (int i = 0; i < NUM_DIGEST; i++) begin
            entry.word  = hash_state[i];
            entry.index = CNT_W'(i);
            entry.last  = (CNT_W'(i) == LAST_INDEX);
            owed_digest_q.push_back(entry);
          end
          for (int i = 0; i < NUM_DIGEST; i++) hash_state[i] = INIT_CHAIN[i];
          bit_length = '0;
          words_held = '0;
        end
      end
    end
    digests_owed = owed_digest_q.size();
  end

endmodule

FILE: sim/tb_top.sv
// testbench top for the sha-1 hash engine: clock, reset, message stimulus and verdict
module tb_top
  import sha1_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [WORD_W-1:0] in_data_word;
  logic [CNT_W-1:0]  in_byte_count;
  logic              in_end_of_message;
  logic              out_valid;
  logic              out_stall;
  logic [WORD_W-1:0] out_digest_word;
  logic [CNT_W-1:0]  out_word_index;
  logic              out_last_digest_word;
  int                mismatches;
  int                digests_owed;
  int                cycle_count = 0;
  int                words_sent = 0;
  bit                in_calm = 1'b0;
  bit                out_calm = 1'b0;

  sha1_hash_engine dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_word         (in_data_word),
    .in_byte_count        (in_byte_count),
    .in_end_of_message    (in_end_of_message),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_digest_word      (out_digest_word),
    .out_word_index       (out_word_index),
    .out_last_digest_word (out_last_digest_word)
  );

  sha1_digest_checker chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_word         (in_data_word),
    .in_byte_count        (in_byte_count),
    .in_end_of_message    (in_end_of_message),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_digest_word      (out_digest_word),
    .out_word_index       (out_word_index),
    .out_last_digest_word (out_last_digest_word),
    .mismatches           (mismatches),
    .digests_owed         (digests_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] data, input logic [CNT_W-1:0] cnt,
                           input logic eom);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_word      <= data;
    in_byte_count     <= cnt;
    in_end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic drain_digests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (digests_owed != 0) @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_data();
    case ($urandom_range(0, 7))
      0:       pick_data = 32'h0000_0000;
      1:       pick_data = 32'hFFFF_FFFF;
      default: pick_data = $urandom;
    endcase
  endfunction

  // result side: random stall length per transaction, with calm stretches
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
      hold = out_calm ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      out_stall <= (hold != 0);
      if (hold != 0) begin
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    int msg_len;
    in_valid          = 1'b0;
    in_data_word      = '0;
    in_byte_count     = '0;
    in_end_of_message = 1'b0;
    rst_n             = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // final word edge cases: empty, partial, full, oversized counts
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_word(32'h0000_0000, 3'd2, 1'b1);
    send_word($urandom, 3'd3, 1'b1);
    send_word(32'hFFFF_FFFF, FULL_COUNT, 1'b1);
    send_word($urandom, 3'd7, 1'b1);
    // short count on a non-final word still counts four bytes
    send_word(32'h0000_0000, 3'd1, 1'b0);
    send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
    // padding spills into a second block
    for (int i = 0; i < 13; i++) send_word($urandom, (i % 2) ? 3'd6 : FULL_COUNT, 1'b0);
    send_word($urandom, FULL_COUNT, 1'b1);
    drain_digests();

    while (words_sent < 275) begin
      if ($urandom_range(0, 4) == 0) in_calm = !in_calm;
      msg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < msg_len - 1; i++) begin
        send_word(pick_data(), ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                          : FULL_COUNT, 1'b0);
      end
      send_word(pick_data(), 3'($urandom_range(0, 7)), 1'b1);
      if ($urandom_range(0, 7) == 0) drain_digests();
    end

    drain_digests();
    repeat (200) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sha1_hash_engine.f
sv/sha1_pkg.sv
sv/sha1_ctrl.sv
sv/sha1_dp.sv
sv/sha1_hash_engine.sv
sv/sha1_checker.sv
sim/sha1_digest_checker.sv
sim/tb_top.sv
